// ----- rtl/core/rsd_pkg.sv -----
`default_nettype none

package rsd_pkg;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SITE_PATTERN = 2'd0,
      CSR_SITE_LENGTH  = 2'd1,
      CSR_CUT_SHIFT    = 2'd2
   } rsd_csr_idx_type;

   // reset values of the configuration registers ("GATC", length 4, offset 0)
   localparam logic [63:0] SITE_PATTERN_RST = 64'h0000_0000_4354_4147;
   localparam logic [3:0]  SITE_LENGTH_RST  = 4'd4;
   localparam logic [3:0]  CUT_SHIFT_RST    = 4'd0;

   // result queue depth and pointer widths
   localparam int RQ_DEPTH = 4;
   localparam int RQ_PTR_W = 2;
   localparam int RQ_CNT_W = 3;

   typedef struct packed {
      logic [63:0] site_pattern;
      logic [3:0]  site_length;
      logic [3:0]  cut_shift;
   } rsd_cfg_type;

   typedef struct packed {
      logic [31:0] fragment_id;
      logic [15:0] fragment_contig;
      logic [31:0] fragment_start;
      logic [31:0] fragment_end;
      logic        last_in_run;
   } rsd_result_type;

   // up to two results pushed per processed item, in order
   typedef struct packed {
      logic [1:0]     count;
      rsd_result_type res0;
      rsd_result_type res1;
   } rsd_push_type;

endpackage

`default_nettype wire

// ----- rtl/core/rsd_req_if.sv -----
`default_nettype none

interface rsd_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  base_byte;
   logic        has_base;
   logic        end_of_contig;
   logic [15:0] contig_number;

   modport source (output valid, base_byte, has_base, end_of_contig, contig_number,
                   input ready);
   modport sink (input valid, base_byte, has_base, end_of_contig, contig_number,
                 output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rsd_rsp_if.sv -----
`default_nettype none

interface rsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] fragment_id;
   logic [15:0] fragment_contig;
   logic [31:0] fragment_start;
   logic [31:0] fragment_end;
   logic        last_in_run;

   modport source (output valid, fragment_id, fragment_contig, fragment_start,
                   fragment_end, last_in_run, input ready);
   modport sink (input valid, fragment_id, fragment_contig, fragment_start,
                 fragment_end, last_in_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rsd_csr_if.sv -----
`default_nettype none

interface rsd_csr_if;
   logic                         valid;
   logic                         ready;
   logic [rsd_pkg::CSR_IDX_W-1:0] index;
   logic [63:0]                  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rsd_csr_regs.sv -----
`default_nettype none

module rsd_csr_regs (
   input  wire logic           clock,
   input  wire logic           reset,
   rsd_csr_if.sink             csr_bus,
   output rsd_pkg::rsd_cfg_type cfg
);

   rsd_pkg::rsd_cfg_type cfg_ff;
   rsd_pkg::rsd_cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            rsd_pkg::CSR_SITE_PATTERN: cfg_in.site_pattern = csr_bus.data;
            rsd_pkg::CSR_SITE_LENGTH:  cfg_in.site_length  = csr_bus.data[3:0];
            rsd_pkg::CSR_CUT_SHIFT:    cfg_in.cut_shift    = csr_bus.data[3:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.site_pattern <= rsd_pkg::SITE_PATTERN_RST;
         cfg_ff.site_length  <= rsd_pkg::SITE_LENGTH_RST;
         cfg_ff.cut_shift    <= rsd_pkg::CUT_SHIFT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/rsd_frag_core.sv -----
`default_nettype none

module rsd_frag_core #(
   parameter int MAX_SITE_LEN = 8,
   parameter int POS_WIDTH    = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   rsd_req_if.sink                   req_bus,
   input  wire rsd_pkg::rsd_cfg_type cfg,
   input  wire logic                 room,
   output rsd_pkg::rsd_push_type     push
);

   localparam int WIN_W = MAX_SITE_LEN * 8;
   localparam int CNT_W = $clog2(MAX_SITE_LEN + 1);

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_has_base_ff;
   logic        in_eoc_ff;
   logic [15:0] in_contig_ff;

   // per-contig and global state
   logic [WIN_W-1:0]     window_ff, window_in;
   logic [CNT_W-1:0]     seen_ff, seen_in;
   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic [POS_WIDTH-1:0] start_ff, start_in;
   logic [31:0]          counter_ff, counter_in;

   logic advance;
   logic emit_cut;
   logic emit_tail;
   logic [POS_WIDTH-1:0] cut;

   assign advance       = in_valid_ff & room;
   assign req_bus.ready = ~in_valid_ff | room;

   always_comb begin
      logic [CNT_W-1:0]     len;
      logic [CNT_W-1:0]     diff;
      logic [WIN_W-1:0]     recent;
      logic                 mismatch;
      logic                 match;
      logic [POS_WIDTH-1:0] lenm1;
      logic [POS_WIDTH-1:0] p;
      logic [POS_WIDTH:0]   cut_sum;
      logic [POS_WIDTH:0]   pos_sum;
      logic [31:0]          id1;

      // clamp the site length to 1..MAX_SITE_LEN
      if (cfg.site_length == 4'd0) begin
         len = CNT_W'(1);
      end else if (cfg.site_length > 4'(MAX_SITE_LEN)) begin
         len = CNT_W'(MAX_SITE_LEN);
      end else begin
         len = CNT_W'(cfg.site_length);
      end

      window_in = window_ff;
      seen_in   = seen_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;

      // newest byte enters at the top
      if (in_has_base_ff) begin
         window_in = WIN_W'({in_byte_ff, window_ff} >> 8);
         if (seen_ff < CNT_W'(MAX_SITE_LEN)) begin
            seen_in = seen_ff + CNT_W'(1);
         end
      end

      // masked compare of the most recent len bytes
      diff     = CNT_W'(MAX_SITE_LEN) - len;
      recent   = window_in >> {diff, 3'b000};
      mismatch = 1'b0;
      for (int k = 0; k < MAX_SITE_LEN; k++) begin
         if ((CNT_W'(k) < len) && (recent[8*k +: 8] != cfg.site_pattern[8*k +: 8])) begin
            mismatch = 1'b1;
         end
      end
      match = in_has_base_ff & (seen_in >= len) & ~mismatch;

      // site start and saturating cut position
      lenm1   = POS_WIDTH'(len) - POS_WIDTH'(1);
      p       = (pos_ff >= lenm1) ? (pos_ff - lenm1) : '0;
      cut_sum = {1'b0, p} + (POS_WIDTH + 1)'(cfg.cut_shift);
      cut     = cut_sum[POS_WIDTH] ? '1 : cut_sum[POS_WIDTH-1:0];

      emit_cut = match & (cut > start_ff);
      if (match) begin
         start_in = cut;
      end

      pos_sum = {1'b0, pos_ff} + (POS_WIDTH + 1)'(1);
      if (in_has_base_ff) begin
         pos_in = pos_sum[POS_WIDTH] ? '1 : pos_sum[POS_WIDTH-1:0];
      end

      // tail fragment, or the empty fragment of an empty contig
      emit_tail = in_eoc_ff & ((start_in < pos_in) | (pos_in == '0));

      id1 = emit_cut ? (counter_ff + 32'd1) : counter_ff;

      push.count = {1'b0, emit_cut} + {1'b0, emit_tail};

      push.res0.fragment_id     = counter_ff;
      push.res0.fragment_contig = in_contig_ff;
      push.res0.fragment_start  = emit_cut ? 32'(start_ff) : 32'(start_in);
      push.res0.fragment_end    = emit_cut ? 32'(cut) : 32'(pos_in);
      push.res0.last_in_run     = ~(emit_cut & emit_tail);

      push.res1.fragment_id     = id1;
      push.res1.fragment_contig = in_contig_ff;
      push.res1.fragment_start  = 32'(start_in);
      push.res1.fragment_end    = 32'(pos_in);
      push.res1.last_in_run     = 1'b1;

      if (~advance) begin
         push.count = 2'd0;
      end

      counter_in = counter_ff + 32'(push.count);

      if (in_eoc_ff) begin
         window_in = '0;
         seen_in   = '0;
         pos_in    = '0;
         start_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_byte_ff     <= req_bus.base_byte;
         in_has_base_ff <= req_bus.has_base;
         in_eoc_ff      <= req_bus.end_of_contig;
         in_contig_ff   <= req_bus.contig_number;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= '0;
         seen_ff    <= '0;
         pos_ff     <= '0;
         start_ff   <= '0;
         counter_ff <= '0;
      end else if (advance) begin
         window_ff  <= window_in;
         seen_ff    <= seen_in;
         pos_ff     <= pos_in;
         start_ff   <= start_in;
         counter_ff <= counter_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/rsd_result_queue.sv -----
`default_nettype none

module rsd_result_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rsd_pkg::rsd_push_type push,
   output logic                       room,
   rsd_rsp_if.source                  rsp_bus
);

   rsd_pkg::rsd_result_type entry_ff [rsd_pkg::RQ_DEPTH];

   logic [rsd_pkg::RQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rsd_pkg::RQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rsd_pkg::RQ_CNT_W-1:0] count_ff, count_in;
   logic [rsd_pkg::RQ_PTR_W-1:0] wr_next;
   logic                         pop;
   rsd_pkg::rsd_result_type      head;

   // room for two beats regardless of this cycle's pop
   assign room    = count_ff <= rsd_pkg::RQ_CNT_W'(rsd_pkg::RQ_DEPTH - 2);
   assign pop     = rsp_bus.valid & rsp_bus.ready;
   assign wr_next = wr_ptr_ff + rsd_pkg::RQ_PTR_W'(1);
   assign head    = entry_ff[rd_ptr_ff];

   assign rsp_bus.valid           = count_ff != '0;
   assign rsp_bus.fragment_id     = head.fragment_id;
   assign rsp_bus.fragment_contig = head.fragment_contig;
   assign rsp_bus.fragment_start  = head.fragment_start;
   assign rsp_bus.fragment_end    = head.fragment_end;
   assign rsp_bus.last_in_run     = head.last_in_run;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + rsd_pkg::RQ_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + rsd_pkg::RQ_PTR_W'(pop);
      count_in  = count_ff + rsd_pkg::RQ_CNT_W'(push.count) - rsd_pkg::RQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.res1;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/restriction_site_digester.sv -----
// restriction_site_digester: streaming in-silico restriction digest
//
// req channel: one beat per sequence byte (has_base), end_of_contig marks the
//   last beat of a contig; a beat with neither has no effect
// rsp channel: one beat per fragment (id, contig, start, end), last_in_run set
//   on the last fragment caused by one request beat; each request beat gives
//   zero, one or two fragments
// csr channel: always ready; writes site pattern, site length and cut shift; the
//   user must write only while the block is idle, which the block does not enforce
// flow: an accepted request beat lands in the input register, is processed
//   into the result queue once it has room; its fragments leave from the head
// throughput: one request beat per cycle while the queue has room; the result
//   queue drains one fragment per cycle; two-fragment beats pace input to that
// reset: state and fragment ids cleared, site back to GATC, length 4, offset 0
// stall: a stalled rsp fills the four-entry result queue; once fewer than two
//   entries are free the input register holds and req ready drops
`default_nettype none

module restriction_site_digester #(
   parameter int MAX_SITE_LEN = 8,
   parameter int POS_WIDTH    = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   rsd_req_if.sink   req_bus,
   rsd_rsp_if.source rsp_bus,
   rsd_csr_if.sink   csr_bus
);

   rsd_pkg::rsd_cfg_type  cfg;
   rsd_pkg::rsd_push_type push;
   logic                  room;

   // configuration registers
   rsd_csr_regs u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // input register, site match and fragment bookkeeping
   rsd_frag_core #(
      .MAX_SITE_LEN (MAX_SITE_LEN),
      .POS_WIDTH    (POS_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .cfg     (cfg),
      .room    (room),
      .push    (push)
   );

   // fragment queue toward the rsp channel
   rsd_result_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .room    (room),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          MAX_SITE       = 8;
   localparam logic [31:0] BASE_LETTERS   = "ACGT";
   localparam int          MISMATCH_SHOWN = 10;
   localparam int          PHASES         = 15;
   localparam int          LONG_HOLD      = 300;

   // one row of the directed table: either a register write or a request beat,
   // optionally with the single fragment it must give typed in by hand
   typedef struct packed {
      logic                     is_csr;
      rsd_pkg::rsd_csr_idx_type idx;
      logic [63:0]              value;
      logic [7:0]               base;
      logic                     has;
      logic                     eoc;
      logic [15:0]              ctg;
      logic                     typed;
      logic                     yields_one;
      logic [31:0]              id;
      logic [31:0]              start;
      logic [31:0]              fin;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rsd_req_if req_if ();
   rsd_rsp_if rsp_if ();
   rsd_csr_if csr_if ();

   restriction_site_digester dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // 20 ns period, starts low
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // digest predictor: own copy of the registers and the scan state
   // ---------------------------------------------------------------------
   logic [63:0] site_bits;
   logic [3:0]  site_len_reg;
   logic [3:0]  cut_reg;

   logic [63:0] win_bytes;     // newest byte in the top lane
   int unsigned seen_cnt;      // bytes of this contig, saturating at MAX_SITE
   logic [31:0] base_pos;      // bases seen in this contig
   logic [31:0] frag_start;    // start of the open fragment
   logic [31:0] next_frag_id;

   // fragments the block still owes, oldest first
   rsd_pkg::rsd_result_type fragments_due[$];
   int unsigned             mismatches = 0;

   // site length as the block uses it: zero acts as one, above MAX_SITE clamps
   function automatic int site_span();
      if (site_len_reg == 4'd0)
         return 1;
      if (site_len_reg > MAX_SITE)
         return MAX_SITE;
      return int'(site_len_reg);
   endfunction

   // positions saturate at all ones instead of wrapping
   function automatic logic [31:0] pos_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic rsd_pkg::rsd_result_type make_fragment(input logic [15:0] ctg,
                                                             input logic [31:0] first,
                                                             input logic [31:0] past);
      rsd_pkg::rsd_result_type f;
      f.fragment_id     = next_frag_id;
      f.fragment_contig = ctg;
      f.fragment_start  = first;
      f.fragment_end    = past;
      f.last_in_run     = 1'b0;
      next_frag_id      = next_frag_id + 32'd1;
      return f;
   endfunction

   // one request beat through the predictor; returns the fragment count
   function automatic int digest_beat(input logic [7:0] b, input logic has, input logic eoc,
                                      input logic [15:0] ctg,
                                      output rsd_pkg::rsd_result_type f0,
                                      output rsd_pkg::rsd_result_type f1);
      int                      n;
      int                      span;
      logic [63:0]             mask;
      logic [63:0]             recent;
      logic [31:0]             first_pos;
      logic [31:0]             cut;
      rsd_pkg::rsd_result_type f;
      n    = 0;
      f0   = '0;
      f1   = '0;
      span = site_span();
      if (has) begin
         win_bytes = {b, win_bytes[63:8]};
         if (seen_cnt < MAX_SITE)
            seen_cnt++;
         if (seen_cnt >= span) begin
            mask   = (span >= 8) ? '1 : ((64'd1 << (8 * span)) - 64'd1);
            recent = win_bytes >> (8 * (8 - span));
            if (recent == (site_bits & mask)) begin
               // base_pos still indexes the byte just taken
               first_pos = (base_pos >= 32'(span - 1)) ? base_pos - 32'(span - 1) : 32'd0;
               cut = pos_add(first_pos, {28'd0, cut_reg});
               // a cut at or before the open start emits nothing but still moves it
               if (cut > frag_start) begin
                  f0 = make_fragment(ctg, frag_start, cut);
                  n  = 1;
               end
               frag_start = cut;
            end
         end
         base_pos = pos_add(base_pos, 32'd1);
      end
      if (eoc) begin
         // empty contig gives [0,0); a cut past the end leaves no tail
         if (frag_start < base_pos || base_pos == 32'd0) begin
            f = make_fragment(ctg, frag_start, base_pos);
            if (n == 0)
               f0 = f;
            else
               f1 = f;
            n++;
         end
         win_bytes  = '0;
         seen_cnt   = 0;
         base_pos   = '0;
         frag_start = '0;
      end
      if (n == 1)
         f0.last_in_run = 1'b1;
      else if (n == 2)
         f1.last_in_run = 1'b1;
      return n;
   endfunction

   // ---------------------------------------------------------------------
   // request side: bursts of beats with random gaps
   // ---------------------------------------------------------------------
   int unsigned gap_max    = 0;   // 0 means back-to-back
   int unsigned burst_left = 0;

   task automatic offer_beat(input logic [7:0] b, input logic has, input logic eoc,
                             input logic [15:0] ctg);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gap_max != 0) begin
            gap = $urandom_range(1, gap_max);
            @(negedge clock);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_if.valid         <= 1'b1;
      req_if.base_byte     <= b;
      req_if.has_base      <= has;
      req_if.end_of_contig <= eoc;
      req_if.contig_number <= ctg;
      do @(posedge clock); while (req_if.ready !== 1'b1);
   endtask

   // offer a beat, then predict it at the edge that took it
   task automatic send_beat(input logic [7:0] b, input logic has, input logic eoc,
                            input logic [15:0] ctg);
      int n;
      rsd_pkg::rsd_result_type f0, f1;
      offer_beat(b, has, eoc, ctg);
      n = digest_beat(b, has, eoc, ctg, f0, f1);
      if (n > 0)
         fragments_due = {fragments_due, f0};
      if (n > 1)
         fragments_due = {fragments_due, f1};
   endtask

   // idle the request side until every fragment is back, then let the
   // pipeline empty out beats that gave none
   task automatic drain_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (fragments_due.size() != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_csr(input rsd_pkg::rsd_csr_idx_type idx, input logic [63:0] value);
      drain_results();
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      case (idx)
         rsd_pkg::CSR_SITE_PATTERN: site_bits    = value;
         rsd_pkg::CSR_SITE_LENGTH:  site_len_reg = value[3:0];
         rsd_pkg::CSR_CUT_SHIFT:    cut_reg      = value[3:0];
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // random contig stream
   // ---------------------------------------------------------------------
   int unsigned contig_left = 0;
   logic        split_end   = 1'b0;   // contig closes with an end-only beat
   logic        end_pending = 1'b0;
   logic [15:0] cur_ctg     = '0;
   int unsigned inject_left = 0;      // site bytes still to copy into the stream
   int unsigned inject_idx  = 0;

   function automatic logic [7:0] letter();
      int k;
      k = $urandom_range(0, 3);
      return BASE_LETTERS[8 * k +: 8];
   endfunction

   function automatic logic [63:0] letter_word();
      logic [63:0] w;
      for (int i = 0; i < 8; i++)
         w[8 * i +: 8] = letter();
      return w;
   endfunction

   task automatic run_random_phase(input int unsigned beats);
      int unsigned sent;
      logic [7:0]  b;
      logic        eoc;
      sent = 0;
      while (sent < beats) begin
         if ($urandom_range(0, 99) < 3) begin
            // beat with neither base nor end: no effect, not counted
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, 16'($urandom_range(0, 65535)));
         end else if (end_pending) begin
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, cur_ctg);
            end_pending = 1'b0;
            sent++;
         end else if (contig_left == 0) begin
            // open a new contig
            cur_ctg   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : cur_ctg + 16'd1;
            split_end = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) begin
               // empty contig
               send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, cur_ctg);
               sent++;
            end else begin
               contig_left = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 160)
                                                          : $urandom_range(1, 40);
            end
         end else begin
            if (inject_left != 0) begin
               b = site_bits[8 * inject_idx +: 8];
               inject_idx++;
               inject_left--;
            end else if ($urandom_range(0, 99) < 20) begin
               // plant a copy of the site so matches are common
               b           = site_bits[7:0];
               inject_idx  = 1;
               inject_left = site_span() - 1;
            end else if ($urandom_range(0, 4) != 0) begin
               b = letter();
            end else begin
               b = 8'($urandom_range(0, 255));
            end
            contig_left--;
            eoc         = (contig_left == 0) && !split_end;
            end_pending = (contig_left == 0) && split_end;
            // contig number changes now and then without an end mark
            if ($urandom_range(0, 49) == 0)
               cur_ctg = 16'($urandom_range(0, 65535));
            send_beat(b, 1'b1, eoc, cur_ctg);
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // response side: own stall pattern plus requested long hold-offs
   // ---------------------------------------------------------------------
   int unsigned hold_requests = 0;

   initial begin
      int unsigned k;
      int unsigned mode;
      int unsigned hold_left;
      int unsigned holds_done;
      logic [7:0]  pat;
      k          = 0;
      mode       = 0;
      hold_left  = 0;
      holds_done = 0;
      pat        = 8'hFF;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            holds_done = hold_requests;
            hold_left  = LONG_HOLD;
         end
         if (hold_left != 0) begin
            // long hold-off so the result queue fills and req ready drops
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            if (k % 64 == 0) begin
               mode = $urandom_range(0, 3);
               pat  = 8'($urandom);
            end
            case (mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= 1'($urandom_range(0, 1));
               2:       rsp_if.ready <= pat[k % 8];
               default: rsp_if.ready <= ($urandom_range(0, 99) < 85);
            endcase
            k++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // fragment checker, sampled at the rising edge
   // ---------------------------------------------------------------------
   rsd_pkg::rsd_result_type got_frag, want_frag;

   task automatic flag_fragment(input string what, input rsd_pkg::rsd_result_type want,
                                input rsd_pkg::rsd_result_type got);
      if (mismatches < MISMATCH_SHOWN) begin
         $write("%0t %s: want id=%0d ctg=%0d [%0d,%0d) last=%0b, ",
                $time, what, want.fragment_id, want.fragment_contig, want.fragment_start,
                want.fragment_end, want.last_in_run);
         $display("got id=%0d ctg=%0d [%0d,%0d) last=%0b",
                  got.fragment_id, got.fragment_contig, got.fragment_start,
                  got.fragment_end, got.last_in_run);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got_frag.fragment_id     = rsp_if.fragment_id;
         got_frag.fragment_contig = rsp_if.fragment_contig;
         got_frag.fragment_start  = rsp_if.fragment_start;
         got_frag.fragment_end    = rsp_if.fragment_end;
         got_frag.last_in_run     = rsp_if.last_in_run;
         if (fragments_due.size() == 0) begin
            flag_fragment("unexpected fragment", '0, got_frag);
         end else begin
            want_frag = fragments_due.pop_front();
            if (got_frag !== want_frag)
               flag_fragment("fragment mismatch", want_frag, got_frag);
         end
      end
   end

   // ---------------------------------------------------------------------
   // directed table builders
   // ---------------------------------------------------------------------
   function automatic plan_row_type csr_row(input rsd_pkg::rsd_csr_idx_type idx,
                                            input logic [63:0] v);
      plan_row_type r;
      r        = '0;
      r.is_csr = 1'b1;
      r.idx    = idx;
      r.value  = v;
      return r;
   endfunction

   function automatic plan_row_type beat_row(input logic [7:0] b, input logic has,
                                             input logic eoc, input logic [15:0] ctg);
      plan_row_type r;
      r      = '0;
      r.idx  = rsd_pkg::CSR_SITE_PATTERN;
      r.base = b;
      r.has  = has;
      r.eoc  = eoc;
      r.ctg  = ctg;
      return r;
   endfunction

   function automatic plan_row_type typed_row(input logic [7:0] b, input logic has,
                                              input logic eoc, input logic [15:0] ctg,
                                              input logic one, input logic [31:0] id,
                                              input logic [31:0] first,
                                              input logic [31:0] past);
      plan_row_type r;
      r            = beat_row(b, has, eoc, ctg);
      r.typed      = 1'b1;
      r.yields_one = one;
      r.id         = id;
      r.start      = first;
      r.fin        = past;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      plan_row_type            plan[$];
      rsd_pkg::rsd_result_type f0, f1;
      rsd_pkg::rsd_result_type typed_frag;
      int                      n;
      logic [63:0]             pat_v;
      logic [3:0]              len_v;
      logic [3:0]              cut_v;
      int unsigned             waited;

      req_if.valid         = 1'b0;
      req_if.base_byte     = '0;
      req_if.has_base      = 1'b0;
      req_if.end_of_contig = 1'b0;
      req_if.contig_number = '0;
      csr_if.valid         = 1'b0;
      csr_if.index         = rsd_pkg::CSR_SITE_PATTERN;
      csr_if.data          = '0;

      // predictor starts from the reset state
      site_bits    = rsd_pkg::SITE_PATTERN_RST;
      site_len_reg = rsd_pkg::SITE_LENGTH_RST;
      cut_reg      = rsd_pkg::CUT_SHIFT_RST;
      win_bytes    = '0;
      seen_cnt     = 0;
      base_pos     = '0;
      frag_start   = '0;
      next_frag_id = '0;

      // after reset: GATC, length 4, cut 0
      plan = {plan, typed_row(8'h00, 1'b0, 1'b1, 16'hFFFF, 1'b1, 32'd0, 32'd0, 32'd0)};
      plan = {plan, typed_row(8'hFF, 1'b0, 1'b0, 16'h1234, 1'b0, '0, '0, '0)};
      plan = {plan, typed_row("G", 1'b1, 1'b0, 16'h0000, 1'b0, '0, '0, '0)};
      plan = {plan, typed_row("A", 1'b1, 1'b0, 16'h0000, 1'b0, '0, '0, '0)};
      plan = {plan, typed_row("T", 1'b1, 1'b0, 16'h0000, 1'b0, '0, '0, '0)};
      // site at position 0 cuts at the open start, so only the tail comes
      plan = {plan, typed_row("C", 1'b1, 1'b1, 16'h0000, 1'b1, 32'd1, 32'd0, 32'd4)};
      // byte extremes ahead of a site, closed by an end-only beat
      plan = {plan, beat_row(8'h00, 1'b1, 1'b0, 16'h0001)};
      plan = {plan, beat_row(8'hFF, 1'b1, 1'b0, 16'h0001)};
      plan = {plan, beat_row("G", 1'b1, 1'b0, 16'h0001)};
      plan = {plan, beat_row("A", 1'b1, 1'b0, 16'h0001)};
      plan = {plan, beat_row("T", 1'b1, 1'b0, 16'h0001)};
      plan = {plan, beat_row("C", 1'b1, 1'b0, 16'h0001)};
      plan = {plan, beat_row(8'h00, 1'b0, 1'b1, 16'h0001)};
      // zero length acts as one, cut offset 15 lands past the contig end
      plan = {plan, csr_row(rsd_pkg::CSR_SITE_PATTERN, 64'h41)};
      plan = {plan, csr_row(rsd_pkg::CSR_SITE_LENGTH, 64'd0)};
      plan = {plan, csr_row(rsd_pkg::CSR_CUT_SHIFT, 64'd15)};
      plan = {plan, beat_row("A", 1'b1, 1'b0, 16'h0002)};
      plan = {plan, beat_row("A", 1'b1, 1'b1, 16'h0002)};
      // overlapping two-byte sites, then a cut change mid contig so the
      // next cut falls behind the open start
      plan = {plan, csr_row(rsd_pkg::CSR_SITE_PATTERN, 64'h4141)};
      plan = {plan, csr_row(rsd_pkg::CSR_SITE_LENGTH, 64'd2)};
      plan = {plan, csr_row(rsd_pkg::CSR_CUT_SHIFT, 64'd3)};
      plan = {plan, beat_row("A", 1'b1, 1'b0, 16'h0003)};
      plan = {plan, beat_row("A", 1'b1, 1'b0, 16'h0003)};
      plan = {plan, beat_row("A", 1'b1, 1'b0, 16'h0003)};
      plan = {plan, csr_row(rsd_pkg::CSR_CUT_SHIFT, 64'd0)};
      plan = {plan, beat_row("A", 1'b1, 1'b0, 16'h0003)};
      // end under another contig number
      plan = {plan, beat_row(8'h00, 1'b0, 1'b1, 16'h0007)};
      // length above the maximum clamps to eight; contig too short to match
      plan = {plan, csr_row(rsd_pkg::CSR_SITE_PATTERN, '1)};
      plan = {plan, csr_row(rsd_pkg::CSR_SITE_LENGTH, 64'd9)};
      plan = {plan, csr_row(rsd_pkg::CSR_CUT_SHIFT, 64'd8)};
      plan = {plan, beat_row(8'hFF, 1'b1, 1'b1, 16'hFFFF)};

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed table
      gap_max = 2;
      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            write_csr(plan[i].idx, plan[i].value);
         end else if (!plan[i].typed) begin
            send_beat(plan[i].base, plan[i].has, plan[i].eoc, plan[i].ctg);
         end else begin
            offer_beat(plan[i].base, plan[i].has, plan[i].eoc, plan[i].ctg);
            // keep predictor state in step; the typed values are the expectation
            n = digest_beat(plan[i].base, plan[i].has, plan[i].eoc, plan[i].ctg, f0, f1);
            if (plan[i].yields_one) begin
               typed_frag.fragment_id     = plan[i].id;
               typed_frag.fragment_contig = plan[i].ctg;
               typed_frag.fragment_start  = plan[i].start;
               typed_frag.fragment_end    = plan[i].fin;
               typed_frag.last_in_run     = 1'b1;
               fragments_due = {fragments_due, typed_frag};
            end
         end
      end

      // random phases, each with a fresh setting; phase borders fall inside
      // contigs, so cuts behind the open start come up too
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               pat_v = letter_word();
               len_v = 4'd1;
               cut_v = 4'd0;
            end
            1: begin
               pat_v = letter_word();
               len_v = 4'd8;
               cut_v = 4'd8;
            end
            2: begin
               pat_v = '1;
               len_v = 4'd15;
               cut_v = 4'd15;
            end
            3: begin
               pat_v = letter_word();
               len_v = 4'd4;
               cut_v = 4'd2;
            end
            4: begin
               pat_v = '0;
               len_v = 4'd0;
               cut_v = 4'd0;
            end
            default: begin
               case ($urandom_range(0, 19))
                  0, 1, 2: pat_v = ($urandom_range(0, 1) != 0) ? '1 : '0;
                  3, 4, 5, 6, 7: pat_v = {$urandom, $urandom};
                  default: pat_v = letter_word();
               endcase
               case ($urandom_range(0, 19))
                  0, 1, 2: len_v = 4'd0;
                  3, 4, 5: len_v = 4'($urandom_range(9, 15));
                  default: len_v = 4'($urandom_range(1, 8));
               endcase
               cut_v = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15))
                                                   : 4'($urandom_range(0, 8));
            end
         endcase
         write_csr(rsd_pkg::CSR_SITE_PATTERN, pat_v);
         write_csr(rsd_pkg::CSR_SITE_LENGTH, {60'd0, len_v});
         write_csr(rsd_pkg::CSR_CUT_SHIFT, {60'd0, cut_v});
         inject_left = 0;

         if (phase == 3 || phase == 11) begin
            // sender keeps offering back to back while rsp holds off
            gap_max = 0;
            hold_requests++;
         end else begin
            case ($urandom_range(0, 2))
               0:       gap_max = 0;
               1:       gap_max = 3;
               default: gap_max = 12;
            endcase
         end
         run_random_phase($urandom_range(100, 120));
      end

      // wait for the last fragments, bounded, then a few more cycles
      @(negedge clock);
      req_if.valid <= 1'b0;
      waited = 0;
      while (fragments_due.size() != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);

      if (fragments_due.size() != 0)
         $display("%0t %0d expected fragments never arrived", $time, fragments_due.size());
      if (mismatches == 0 && fragments_due.size() == 0)
         $display("[restriction_site_digester] OK");
      else
         $display("[restriction_site_digester] ERROR");
      $finish;
   end

   // run limit
   initial begin
      #8_000_000;
      $display("[restriction_site_digester] ERROR");
      $finish;
   end

endmodule
